/* rtl/cbtr_pkg.sv */
package cbtr_pkg;

  // Segment codes, as they appear in the result
  localparam logic [1:0] SEG_SYNC = 2'd0;
  localparam logic [1:0] SEG_P1   = 2'd1;
  localparam logic [1:0] SEG_P2   = 2'd2;

  // Register reset values
  localparam logic [4:0] RESET_PHASE1 = 5'd10;
  localparam logic [4:0] RESET_PHASE2 = 5'd10;
  localparam logic [3:0] RESET_JUMP   = 4'd5;

  // Register indexes on the config port
  localparam logic [1:0] REG_PHASE1 = 2'd0;
  localparam logic [1:0] REG_PHASE2 = 2'd1;
  localparam logic [1:0] REG_JUMP   = 2'd2;

  typedef struct packed {
    logic [4:0] phase1_quanta;
    logic [4:0] phase2_quanta;
    logic [3:0] jump_width;
  } cfg_t;

  typedef struct packed {
    logic [6:0] quantum_count;
    logic       sample_point;
    logic       write_point;
    logic [1:0] segment;
  } result_t;

endpackage

/* rtl/cbtr_timing.sv */
module cbtr_timing (
  input  logic             clk,
  input  logic             rst,
  input  cbtr_pkg::cfg_t   cfg,
  input  logic             accept,
  input  logic             edge_seen,
  output cbtr_pkg::result_t result
);
  import cbtr_pkg::*;

  logic [1:0] seg_state;
  logic [6:0] count;
  logic [5:0] seg1_len;
  logic [4:0] seg2_len;
  logic       edge_pend;

  logic [1:0] seg_state_next;
  logic [5:0] seg1_len_next;
  logic [4:0] seg2_len_next;
  logic       edge_pend_next;

  logic       pend;
  logic [6:0] jw7;
  logic       grow_ok;
  logic [6:0] jump1;
  logic [5:0] seg1_new;
  logic       shrink_ok;
  logic [6:0] end_pt;
  logic [6:0] rem;
  logic [6:0] jump2;
  logic [4:0] seg2_new;
  logic [6:0] end_new;

  assign pend = edge_pend | edge_seen;
  assign jw7  = {3'b000, cfg.jump_width};

  // Phase 1: lengthen once while still nominal
  assign grow_ok  = pend && (seg1_len == {1'b0, cfg.phase1_quanta});
  assign jump1    = (jw7 < count) ? jw7 : count;
  assign seg1_new = grow_ok ? seg1_len + jump1[5:0] : seg1_len;

  // Phase 2: shorten once while nominal, by min(jump, distance to end)
  assign shrink_ok = pend && (seg2_len == cfg.phase2_quanta);
  assign end_pt    = {1'b0, seg1_len} + {2'b00, seg2_len};
  assign rem       = (end_pt >= count) ? end_pt - count : count - end_pt;
  assign jump2     = (jw7 < rem) ? jw7 : rem;
  assign seg2_new  = shrink_ok ? seg2_len - jump2[4:0] : seg2_len;
  assign end_new   = {1'b0, seg1_len} + {2'b00, seg2_new};

  // Next state and result for the current tick
  always_comb begin
    seg_state_next     = seg_state;
    seg1_len_next      = seg1_len;
    seg2_len_next      = seg2_len;
    edge_pend_next     = pend;
    result.segment       = seg_state;
    result.write_point   = 1'b0;
    result.sample_point  = 1'b0;
    result.quantum_count = count;
    case (seg_state)
      SEG_SYNC: begin
        seg1_len_next        = {1'b0, cfg.phase1_quanta};
        seg2_len_next        = cfg.phase2_quanta;
        edge_pend_next       = 1'b0;
        seg_state_next       = SEG_P1;
        result.write_point   = 1'b1;
        result.quantum_count = 7'd0;
      end
      SEG_P1: begin
        seg1_len_next = seg1_new;
        if (grow_ok) begin
          edge_pend_next = 1'b0;
        end
        if (count == {1'b0, seg1_new}) begin
          result.sample_point = 1'b1;
          seg_state_next      = SEG_P2;
        end
      end
      default: begin
        seg2_len_next = seg2_new;
        if (shrink_ok) begin
          edge_pend_next = 1'b0;
        end
        if (count == end_new) begin
          seg_state_next = SEG_SYNC;
        end
      end
    endcase
  end

  // State update, one tick per accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_state <= SEG_SYNC;
      count     <= 7'd0;
      seg1_len  <= {1'b0, RESET_PHASE1};
      seg2_len  <= RESET_PHASE2;
      edge_pend <= 1'b0;
    end else if (accept) begin
      seg_state <= seg_state_next;
      count     <= result.quantum_count + 7'd1;
      seg1_len  <= seg1_len_next;
      seg2_len  <= seg2_len_next;
      edge_pend <= edge_pend_next;
    end
  end

  a_reset_state: assert property (@(posedge clk)
    rst |=> (seg_state == SEG_SYNC) && !edge_pend && (count == 7'd0))
    else $error("state not cleared by reset");

  a_sync_to_p1: assert property (@(posedge clk) disable iff (rst)
    (accept && seg_state == SEG_SYNC) |=> (seg_state == SEG_P1) && (count == 7'd1) && !edge_pend)
    else $error("sync tick did not restart the bit");

  a_sample_to_p2: assert property (@(posedge clk) disable iff (rst)
    (accept && result.sample_point) |=> (seg_state == SEG_P2))
    else $error("sample point without entering phase 2");

  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(count) && $stable(seg_state) && $stable(edge_pend))
    else $error("state moved without an item");

endmodule

/* rtl/can_bit_timing_resync_top.sv */
// A result is presented in the cycle after its tick item is accepted.
// Throughput: one item per cycle; the state update is a single registered pass
// and the output register lets the next item in while a result is taken.
// Reset (rst, synchronous, active high): sync segment, counter zero, no edge
// pending, registers back to phase1 10, phase2 10, jump width 5, no result held.
module can_bit_timing_resync_top (
  input  logic        clk,
  input  logic        rst,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // tick items in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] edge_seen
  // results out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [1:0] segment, [2] write_point, [3] sample_point,
                                 // [10:4] quantum_count
);
  import cbtr_pkg::*;

  cfg_t    cfg;
  logic    wr_en;
  logic    accept;
  result_t result;
  result_t res_q;
  logic    out_valid;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase1_quanta <= RESET_PHASE1;
      cfg.phase2_quanta <= RESET_PHASE2;
      cfg.jump_width    <= RESET_JUMP;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_PHASE1: cfg.phase1_quanta <= pwdata[4:0];
        REG_PHASE2: cfg.phase2_quanta <= pwdata[4:0];
        REG_JUMP:   cfg.jump_width    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (paddr[3:2])
      REG_PHASE1: prdata = {27'd0, cfg.phase1_quanta};
      REG_PHASE2: prdata = {27'd0, cfg.phase2_quanta};
      REG_JUMP:   prdata = {28'd0, cfg.jump_width};
      default:    prdata = 32'd0;
    endcase
  end

  // Take a tick whenever the output register is free or being emptied
  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  cbtr_timing u_timing (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .edge_seen (s_tdata[0]),
    .result    (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, res_q.quantum_count, res_q.sample_point,
                     res_q.write_point, res_q.segment};

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

import cbtr_pkg::*;

// Bit timing predictor plus the queue of per-tick results it expects
class tick_model;
  logic [4:0] p1_cfg;
  logic [4:0] p2_cfg;
  logic [3:0] jw_cfg;
  logic [1:0] seg_state;
  logic [6:0] count;
  logic [5:0] len1;
  logic [4:0] len2;
  logic       pending;
  result_t    expected_ticks[$];
  int         mismatches;

  function new();
    p1_cfg      = RESET_PHASE1;
    p2_cfg      = RESET_PHASE2;
    jw_cfg      = RESET_JUMP;
    seg_state   = SEG_SYNC;
    count       = '0;
    len1        = {1'b0, RESET_PHASE1};
    len2        = RESET_PHASE2;
    pending     = 1'b0;
    mismatches  = 0;
  endfunction

  // Register writes must land only while the block is idle; not enforced here
  function void write_reg(logic [1:0] idx, logic [31:0] data);
    case (idx)
      REG_PHASE1: p1_cfg = data[4:0];
      REG_PHASE2: p2_cfg = data[4:0];
      REG_JUMP:   jw_cfg = data[3:0];
      default: ;
    endcase
  endfunction

  // Advance one time quantum and queue the result it produces
  function void note_tick(logic rx_edge);
    result_t     exp_r;
    int unsigned jump;
    int unsigned stop;
    int unsigned rem;
    exp_r = '0;
    exp_r.segment = seg_state;
    pending = pending | rx_edge;
    case (seg_state)
      SEG_SYNC: begin
        count   = '0;
        len1    = {1'b0, p1_cfg};
        len2    = p2_cfg;
        pending = 1'b0;
        exp_r.write_point = 1'b1;
        seg_state = SEG_P1;
      end
      SEG_P1: begin
        // lengthen once, only while segment 1 is still nominal
        if (pending && len1 == {1'b0, p1_cfg}) begin
          pending = 1'b0;
          jump = (jw_cfg < count) ? jw_cfg : count;
          len1 = len1 + 6'(jump);
        end
        if (count == {1'b0, len1}) begin
          exp_r.sample_point = 1'b1;
          seg_state = SEG_P2;
        end
      end
      default: begin
        // shorten once, by no more than what is left of the bit
        if (pending && len2 == p2_cfg) begin
          stop = len1 + len2;
          rem  = (stop >= count) ? stop - count : count - stop;
          jump = (jw_cfg < rem) ? jw_cfg : rem;
          pending = 1'b0;
          len2 = len2 - 5'(jump);
        end
        stop = len1 + len2;
        if (count == stop) seg_state = SEG_SYNC;
      end
    endcase
    exp_r.quantum_count = count;
    count = count + 7'd1;
    expected_ticks.push_back(exp_r);
  endfunction

  function void check_result(logic [15:0] data);
    result_t got;
    result_t exp_r;
    got = data[10:0];
    if (expected_ticks.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result with no tick outstanding: %h", data);
    end else begin
      exp_r = expected_ticks.pop_front();
      if (got.segment !== exp_r.segment || got.write_point !== exp_r.write_point ||
          got.sample_point !== exp_r.sample_point ||
          got.quantum_count !== exp_r.quantum_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tick mismatch (exp/got): seg %0d/%0d wp %0b/%0b sp %0b/%0b qc %0d/%0d",
                   exp_r.segment, got.segment, exp_r.write_point, got.write_point,
                   exp_r.sample_point, got.sample_point,
                   exp_r.quantum_count, got.quantum_count);
      end
    end
  endfunction
endclass

module tb_top;

  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG    = 3000;
  localparam int PHASES      = 10;
  localparam int PHASE_TICKS = 80;

  logic        clk;
  logic        rst      = 1'b1;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [3:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;   // [0] edge_seen
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;         // [1:0] segment, [2] write_point, [3] sample_point,
                                // [10:4] quantum_count

  tick_model timing;
  bit        hold_req  = 1'b0;
  bit        rx_steady = 1'b0;

  can_bit_timing_resync_top dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [4:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 5'd1;
    if (r < 30) return 5'd31;
    return 5'($urandom_range(1, 6));
  endfunction

  function automatic logic [3:0] pick_jump();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 4'd0;
    if (r < 30) return 4'd15;
    return 4'($urandom_range(0, 4));
  endfunction

  // setup then access cycle; unused upper data bits are random
  task automatic write_reg(logic [1:0] idx, logic [4:0] value);
    logic [31:0] data;
    data = ($urandom() << 5) | 32'(value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    timing.write_reg(idx, data);
  endtask

  task automatic send_tick(logic rx_edge, bit no_gap);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, rx_edge};
    do @(posedge clk); while (!s_tready);
    timing.note_tick(rx_edge);
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering and wait for every expected result
  task automatic drain();
    s_tvalid <= 1'b0;
    while (timing.expected_ticks.size() != 0) @(posedge clk);
  endtask

  // receiver: checks results and stalls at random, or for a long hold on request
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) timing.check_result(m_tdata);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        stall = rx_steady ? 0 : pick_gap();
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
      else idle++;
      if (idle >= WATCHDOG) begin
        $display("can_bit_timing_resync_top test failed");
        $finish;
      end
    end
  end

  initial begin
    logic [3:0] warm_edges;
    logic [9:0] mid_edges;
    logic [9:0] dense_edges;
    int         odds;
    bit         no_gap;
    // sync tick with an edge (dropped), then edges early in phase 1
    warm_edges  = 4'b1101;
    // applied mid-bit: segment lengths differ from the new nominal values
    mid_edges   = 10'b1001110101;
    // zero jump width: edges consumed repeatedly without moving the end point
    dense_edges = 10'b1111011111;
    timing = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    for (int i = 0; i < 4; i++) send_tick(warm_edges[i], 1'b0);
    drain();
    write_reg(REG_PHASE1, 5'd2);
    write_reg(REG_PHASE2, 5'd2);
    write_reg(REG_JUMP, 5'd1);
    for (int i = 0; i < 10; i++) send_tick(mid_edges[i], 1'b0);
    drain();
    write_reg(REG_PHASE1, 5'd1);
    write_reg(REG_PHASE2, 5'd31);
    write_reg(REG_JUMP, 5'd0);
    for (int i = 0; i < 10; i++) send_tick(dense_edges[i], 1'b1);
    drain();

    // random phases, each with its own settings and edge density
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1) begin
        write_reg(REG_PHASE1, RESET_PHASE1);
        write_reg(REG_PHASE2, RESET_PHASE2);
        write_reg(REG_JUMP, {1'b0, RESET_JUMP});
      end else begin
        write_reg(REG_PHASE1, pick_len());
        write_reg(REG_PHASE2, pick_len());
        write_reg(REG_JUMP, {1'b0, pick_jump()});
      end
      case ($urandom_range(0, 2))
        0: odds = 2;
        1: odds = 6;
        default: odds = 20;
      endcase
      rx_steady = ($urandom_range(0, 3) == 0);
      no_gap = ($urandom_range(0, 3) == 0);
      // long receiver hold while the sender keeps pushing
      if (ph == 3) begin
        rx_steady = 1'b0;
        no_gap = 1'b1;
        hold_req = 1'b1;
      end
      for (int i = 0; i < PHASE_TICKS; i++)
        send_tick($urandom_range(0, odds - 1) == 0, no_gap);
      drain();
    end

    repeat (10) @(posedge clk);
    if (timing.mismatches == 0 && timing.expected_ticks.size() == 0) begin
      $display("can_bit_timing_resync_top test passed");
    end else begin
      $display("can_bit_timing_resync_top test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/cbtr_pkg.sv
rtl/cbtr_timing.sv
rtl/can_bit_timing_resync_top.sv
verif/tb_top.sv
